### rtl/ffas_pkg.sv
// types and codes shared by the first-fit aligned suballocator
package ffas_pkg;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NO_TAG   = 2'd3;

	localparam logic [0:0] REG_CHUNK_SIZE = 1'd0;
	localparam logic [0:0] REG_GRAN_LOG2  = 1'd1;

	typedef struct packed {
		logic        op;
		logic [15:0] tag;
		logic [31:0] req_size;
		logic [4:0]  align_log2;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] offset;
	} rsp_t;
endpackage

### rtl/first_fit_aligned_suballocator_unit.sv
// first-fit aligned suballocator top level
// A request is taken at a rising edge with start high and busy low. Exactly one result
// beat follows: rsp holds status and offset for the single cycle that done is high,
// which is the cycle in which busy falls, and the receiver cannot stall it. Every
// offset sum goes through one shared adder under a small sequencer. A free scans one
// entry a cycle and then moves later entries down one a cycle. An allocate checks one
// gap at a time, stepping through read, round the start, add the size, pad and compare,
// and then moves later entries up one a cycle. A full table answers without a search,
// and an empty one without a gap search, at offset zero if the block fits. A new
// request can be taken in the cycle of the result beat.
module first_fit_aligned_suballocator_unit #(
	parameter int MAX_BLOCKS  = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ffas_pkg::req_t      req,
	output logic                busy,
	output logic                done,
	output ffas_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);
	import ffas_pkg::*;

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int OW = OFFSET_BITS;
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	localparam logic [3:0] S_IDLE = 4'd0, S_FSCAN = 4'd1, S_FSHIFT = 4'd2,
		S_EMPTY = 4'd3, S_RD = 4'd4, S_RND = 4'd5, S_SUM = 4'd6, S_PAD = 4'd7,
		S_ISHIFT = 4'd8, S_IWRITE = 4'd9, S_DONE = 4'd10;

	logic [15:0]   mem_tag [MAX_BLOCKS];
	logic [OW-1:0] mem_off [MAX_BLOCKS];
	logic [OW-1:0] mem_end [MAX_BLOCKS];

	logic [3:0]    st_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] pos_q;
	logic [31:0]   chunk_q;
	logic [4:0]    gran_q;
	req_t          req_q;
	logic [1:0]    status_q;
	logic [OW-1:0] off_q, loc_q, prevend_q, next_q, newend_q;
	logic          ok_q;

	logic [OW-1:0] add_a, add_b;
	logic          add_cin;
	logic [OW:0]   add_s;

	logic [OW-1:0] amask, gmask, size_w, chunk_w, end_w;
	logic          size_ok, gpad, pad_w, fit_w;
	logic [IW-1:0] ix;

	// shared adder with carry in and overflow flag
	assign add_s = {1'b0, add_a} + {1'b0, add_b} + {{OW{1'b0}}, add_cin};

	assign amask = OW'((65'd1 << req_q.align_log2) - 65'd1);
	assign gmask = OW'((65'd1 << gran_q) - 65'd1);
	assign gpad  = gran_q > req_q.align_log2;
	assign size_ok = (OW >= 32) || ((64'(req_q.req_size) >> OW) == 64'd0);
	assign size_w  = OW'(req_q.req_size);
	assign chunk_w = ((OW < 32) && ((64'(chunk_q) >> OW) != 64'd0)) ? '1 : OW'(chunk_q);
	assign ix = i_q[IW-1:0];

	// granularity pad on the block end and the gap check
	assign pad_w = gpad && ((newend_q & gmask) != '0);
	assign end_w = pad_w ? add_s[OW-1:0] : newend_q;
	assign fit_w = ok_q && !(pad_w && add_s[OW]) && (next_q > end_w);

	always_comb begin
		add_a = '0;
		add_b = '0;
		add_cin = 1'b0;
		case (st_q)
			S_EMPTY: begin
				add_a = size_w | gmask;
				add_cin = 1'b1;
			end
			S_RND: begin
				add_a = prevend_q | amask;
				add_cin = 1'b1;
			end
			S_SUM: begin
				add_a = loc_q;
				add_b = size_w;
			end
			S_PAD: begin
				add_a = newend_q | gmask;
				add_cin = 1'b1;
			end
			default: begin
				add_a = '0;
				add_b = '0;
				add_cin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			pos_q     <= '0;
			chunk_q   <= 32'd268435456;
			gran_q    <= '0;
			req_q     <= '0;
			status_q  <= ST_OK;
			off_q     <= '0;
			loc_q     <= '0;
			prevend_q <= '0;
			next_q    <= '0;
			newend_q  <= '0;
			ok_q      <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_CHUNK_SIZE) chunk_q <= cfg_data;
				else if (cfg_index == REG_GRAN_LOG2) gran_q <= cfg_data[4:0];
			end
			case (st_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						i_q <= '0;
						off_q <= '0;
						if (req.op == OP_FREE) begin
							status_q <= ST_NO_TAG;
							st_q <= S_FSCAN;
						end else if (cnt_q >= MAXC) begin
							status_q <= ST_FULL;
							st_q <= S_DONE;
						end else begin
							status_q <= ST_NO_SPACE;
							st_q <= (cnt_q == '0) ? S_EMPTY : S_RD;
						end
					end
				end
				S_FSCAN: begin
					if (i_q >= cnt_q) st_q <= S_DONE;
					else if (mem_tag[ix] == req_q.tag) begin
						status_q <= ST_OK;
						st_q <= S_FSHIFT;
					end else i_q <= i_q + CW'(1);
				end
				S_FSHIFT: begin
					if (i_q + CW'(1) < cnt_q) i_q <= i_q + CW'(1);
					else begin
						cnt_q <= cnt_q - CW'(1);
						st_q <= S_DONE;
					end
				end
				S_EMPTY: begin
					loc_q <= '0;
					pos_q <= '0;
					if (!size_ok) st_q <= S_DONE;
					else if (gpad && (size_w & gmask) != '0) begin
						if (add_s[OW]) st_q <= S_DONE;
						else begin
							newend_q <= add_s[OW-1:0];
							st_q <= S_IWRITE;
						end
					end else begin
						newend_q <= size_w;
						st_q <= S_IWRITE;
					end
				end
				S_RD: begin
					prevend_q <= mem_end[ix];
					next_q <= (i_q + CW'(1) == cnt_q) ? chunk_w : mem_off[IW'(i_q + CW'(1))];
					ok_q <= size_ok;
					st_q <= S_RND;
				end
				S_RND: begin
					if ((prevend_q & amask) != '0) begin
						loc_q <= add_s[OW-1:0];
						if (add_s[OW]) ok_q <= 1'b0;
					end else loc_q <= prevend_q;
					st_q <= S_SUM;
				end
				S_SUM: begin
					newend_q <= add_s[OW-1:0];
					if (add_s[OW]) ok_q <= 1'b0;
					st_q <= S_PAD;
				end
				S_PAD: begin
					if (fit_w) begin
						newend_q <= end_w;
						pos_q <= i_q + CW'(1);
						i_q <= cnt_q;
						st_q <= S_ISHIFT;
					end else if (i_q + CW'(1) >= cnt_q) st_q <= S_DONE;
					else begin
						i_q <= i_q + CW'(1);
						st_q <= S_RD;
					end
				end
				S_ISHIFT: begin
					if (i_q == pos_q) st_q <= S_IWRITE;
					else i_q <= i_q - CW'(1);
				end
				S_IWRITE: begin
					cnt_q <= cnt_q + CW'(1);
					status_q <= ST_OK;
					off_q <= loc_q;
					st_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FSHIFT && i_q + CW'(1) < cnt_q) begin
			mem_tag[ix] <= mem_tag[IW'(i_q + CW'(1))];
			mem_off[ix] <= mem_off[IW'(i_q + CW'(1))];
			mem_end[ix] <= mem_end[IW'(i_q + CW'(1))];
		end
		if (st_q == S_ISHIFT && i_q != pos_q) begin
			mem_tag[ix] <= mem_tag[IW'(i_q - CW'(1))];
			mem_off[ix] <= mem_off[IW'(i_q - CW'(1))];
			mem_end[ix] <= mem_end[IW'(i_q - CW'(1))];
		end
		if (st_q == S_IWRITE) begin
			mem_tag[IW'(pos_q)] <= req_q.tag;
			mem_off[IW'(pos_q)] <= loc_q;
			mem_end[IW'(pos_q)] <= newend_q;
		end
	end

	assign busy = (st_q != S_IDLE);
	assign rsp = {status_q, 32'(off_q)};
endmodule

### tb/tb_first_fit_aligned_suballocator_unit.sv
// testbench for the first-fit aligned suballocator: directed and random requests checked against a predictor
module tb_first_fit_aligned_suballocator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ffas_pkg::*;

	localparam int DEPTH = 16;
	localparam longint unsigned OMAX = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy, done;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	first_fit_aligned_suballocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [31:0] pool_size = 32'd268435456;
	logic [4:0]  pool_gran = 5'd0;
	logic [15:0] blk_tag [DEPTH];
	longint unsigned blk_off [DEPTH];
	longint unsigned blk_end [DEPTH];
	int blk_count = 0;

	req_t pending_reqs [$];
	rsp_t awaited_rsps [$];
	int errors = 0;
	bit quiet = 1'b0;
	int gap_left = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic bit add_ok(input longint unsigned a, input longint unsigned b,
			output longint unsigned r);
		r = a + b;
		return r <= OMAX;
	endfunction

	function automatic rsp_t allocate_or_free(input req_t r);
		rsp_t o;
		longint unsigned al, gr, loc, blk, t, rem, nxt, space, e;
		bit ok, gpad;
		o.status = ST_NO_SPACE;
		o.offset = '0;
		if (r.op == OP_FREE) begin
			o.status = ST_NO_TAG;
			for (int i = 0; i < blk_count; i++) begin
				if (blk_tag[i] == r.tag) begin
					for (int k = i; k + 1 < blk_count; k++) begin
						blk_tag[k] = blk_tag[k+1];
						blk_off[k] = blk_off[k+1];
						blk_end[k] = blk_end[k+1];
					end
					blk_count--;
					o.status = ST_OK;
					break;
				end
			end
			return o;
		end
		if (blk_count >= DEPTH) begin
			o.status = ST_FULL;
			return o;
		end
		al = 64'd1 << r.align_log2;
		gr = 64'd1 << pool_gran;
		gpad = pool_gran > r.align_log2;
		if (blk_count == 0) begin
			e = r.req_size;
			ok = 1'b1;
			if (gpad && (e & (gr - 1)) != 0)
				ok = add_ok(e, gr - (e & (gr - 1)), e);
			if (ok) begin
				blk_tag[0] = r.tag;
				blk_off[0] = 0;
				blk_end[0] = e;
				blk_count = 1;
				o.status = ST_OK;
			end
			return o;
		end
		for (int i = 0; i < blk_count; i++) begin
			loc = blk_end[i];
			blk = r.req_size;
			ok = 1'b1;
			rem = loc & (al - 1);
			if (rem != 0)
				ok = add_ok(loc, al - rem, loc) && add_ok(blk, al - rem, blk);
			if (ok && gpad) begin
				ok = add_ok(loc, r.req_size, t);
				rem = t & (gr - 1);
				if (ok && rem != 0)
					ok = add_ok(blk, gr - rem, blk);
			end
			nxt = (i + 1 == blk_count) ? longint'(pool_size) : blk_off[i+1];
			space = nxt > blk_end[i] ? nxt - blk_end[i] : 0;
			if (ok && space > blk) begin
				for (int k = blk_count; k > i + 1; k--) begin
					blk_tag[k] = blk_tag[k-1];
					blk_off[k] = blk_off[k-1];
					blk_end[k] = blk_end[k-1];
				end
				blk_tag[i+1] = r.tag;
				blk_off[i+1] = loc;
				blk_end[i+1] = blk_end[i] + blk;
				blk_count++;
				o.status = ST_OK;
				o.offset = loc[31:0];
				break;
			end
		end
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				awaited_rsps.insert(awaited_rsps.size(), allocate_or_free(req));
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					if (!quiet && $urandom_range(0, 7) == 0) begin
						start <= 1'b0;
						gap_left = $urandom_range(0, 10);
					end else begin
						req <= pending_reqs.pop_front();
						start <= 1'b1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			if (awaited_rsps.size() == 0) begin
				report($sformatf("unexpected beat status=%0d offset=%h",
					rsp.status, rsp.offset));
			end else begin
				exp_rsp = awaited_rsps.pop_front();
				if (rsp.status !== exp_rsp.status)
					report($sformatf("status got %0d exp %0d", rsp.status, exp_rsp.status));
				if (rsp.offset !== exp_rsp.offset)
					report($sformatf("offset got %h exp %h", rsp.offset, exp_rsp.offset));
			end
		end
	end

	function automatic req_t make_req(input logic op, input logic [15:0] tag,
			input logic [31:0] sz, input logic [4:0] al);
		req_t r;
		r.op = op;
		r.tag = tag;
		r.req_size = sz;
		r.align_log2 = al;
		return r;
	endfunction

	function automatic logic [31:0] rand_size(input logic [31:0] pool);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 3);
			2: return pool >> $urandom_range(1, 6);
			default: return $urandom_range(1, 32'h1000) << $urandom_range(0, 12);
		endcase
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || start || busy || awaited_rsps.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHUNK_SIZE)
			pool_size = val;
		else
			pool_gran = val[4:0];
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] tags [$];
		logic [15:0] tg;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		pending_reqs.insert(pending_reqs.size(), make_req(OP_FREE, 16'h1234, 32'd0, 5'd0));
		pending_reqs.insert(pending_reqs.size(), make_req(OP_ALLOC, 16'h0000, 32'h0, 5'd0));
		pending_reqs.insert(pending_reqs.size(),
			make_req(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
		pending_reqs.insert(pending_reqs.size(), make_req(OP_ALLOC, 16'h0001, 32'd100, 5'd31));
		pending_reqs.insert(pending_reqs.size(), make_req(OP_ALLOC, 16'h0002, 32'd7, 5'd4));
		for (int i = 0; i < 15; i++)
			pending_reqs.insert(pending_reqs.size(),
				make_req(OP_ALLOC, 16'(16'h100 + i), 32'd33, 5'd3));
		pending_reqs.insert(pending_reqs.size(), make_req(OP_FREE, 16'h0000, 32'd0, 5'd0));
		pending_reqs.insert(pending_reqs.size(), make_req(OP_FREE, 16'h0002, 32'd0, 5'd0));
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_CHUNK_SIZE, 32'hFFFF_FFFF);
					write_reg(REG_GRAN_LOG2, 32'd31);
				end
				1: begin
					write_reg(REG_CHUNK_SIZE, 32'd0);
					write_reg(REG_GRAN_LOG2, 32'd0);
				end
				2: begin
					write_reg(REG_CHUNK_SIZE, 32'h0001_0000);
					write_reg(REG_GRAN_LOG2, 32'd6);
				end
				3: write_reg(REG_CHUNK_SIZE, 32'hFFFF_FFF0);
				4: write_reg(REG_GRAN_LOG2, 32'd12);
				5: begin
					write_reg(REG_CHUNK_SIZE, $urandom());
					write_reg(REG_GRAN_LOG2, $urandom());
				end
				6: begin
					write_reg(REG_CHUNK_SIZE, 32'h0100_0000);
					write_reg(REG_GRAN_LOG2, 32'd2);
				end
				default: write_reg(REG_GRAN_LOG2, 32'd0);
			endcase
			if (ph == 7)
				quiet = 1'b1;
			tags.delete();
			n = 240;
			for (int i = 0; i < n; i++) begin
				if (tags.size() > 0 && $urandom_range(0, 2) == 0) begin
					tg = tags[$urandom_range(0, tags.size() - 1)];
					if ($urandom_range(0, 9) == 0)
						tg = 16'($urandom());
					pending_reqs.insert(pending_reqs.size(),
						make_req(OP_FREE, tg, $urandom(), 5'($urandom())));
				end else begin
					tg = 16'($urandom());
					tags.insert(tags.size(), tg);
					if (tags.size() > 40)
						void'(tags.pop_front());
					pending_reqs.insert(pending_reqs.size(),
						make_req(OP_ALLOC, tg, rand_size(pool_size),
						$urandom_range(0, 3) == 0 ? 5'($urandom()) : 5'($urandom_range(0, 8))));
				end
			end
			drain();
		end
		if (errors == 0)
			$display("first_fit_aligned_suballocator_unit regression: pass");
		else
			$display("first_fit_aligned_suballocator_unit regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("first_fit_aligned_suballocator_unit regression: fail");
		$finish;
	end
endmodule
